// ----- src/cbs_pkg.sv -----
// shared types, constants and helper functions of the companion module boot sequencer
`default_nettype none
package cbs_pkg;

  localparam int unsigned TIMER_BITS = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_NUM    = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CFG_W-1:0]      cfg_word_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  localparam cfg_idx_t CFG_POWER_OFF_WAIT    = 3'd0;
  localparam cfg_idx_t CFG_POWER_TO_CMD_WAIT = 3'd1;
  localparam cfg_idx_t CFG_CMD_HOLD_TIME     = 3'd2;
  localparam cfg_idx_t CFG_BOOT_POWER_WAIT   = 3'd3;
  localparam cfg_idx_t CFG_LONG_PRESS_TIME   = 3'd4;
  localparam cfg_idx_t CFG_PULSE_LENGTH      = 3'd5;

  localparam cfg_word_t CFG_RESET [CFG_NUM] = '{
    16'd100, 16'd300, 16'd50, 16'd100, 16'd100, 16'd20
  };

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_ON,
    MODE_PAIR,
    MODE_BOOT
  } mode_e;

  typedef enum logic [2:0] {
    STG_IDLE,
    STG_WAIT_PWR,
    STG_CMD_ON,
    STG_CMD_OFF,
    STG_MONITOR,
    STG_BOOT_PWR
  } stage_e;

  typedef enum logic [1:0] {
    UI_LISTEN,
    UI_ANSWER,
    UI_REST,
    UI_OTHER
  } ui_e;

  typedef struct packed {
    cfg_word_t power_off_wait;
    cfg_word_t power_to_cmd_wait;
    cfg_word_t cmd_hold_time;
    cfg_word_t boot_power_wait;
    cfg_word_t long_press_time;
    cfg_word_t pulse_length;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] new_mode;
    logic       key;
    ui_e        ui;
    logic       voice;
    logic       busy;
  } item_t;

  typedef struct packed {
    mode_e  mode;
    stage_e stage;
    timer_t stage_timer;
    logic   press_seen;
    timer_t press_timer;
    logic   long_ready;
    logic   wait_release;
    logic   pulse_active;
    timer_t pulse_timer;
    logic   pwr;
    logic   boot;
    logic   audio;
    logic   bridge;
  } state_t;

  function automatic timer_t sat_inc(timer_t t);
    return (&t) ? t : t + timer_t'(1);
  endfunction

  // a limit above the saturation value is never reached
  function automatic logic reached(timer_t t, cfg_word_t lim);
    return CMP_W'(t) >= CMP_W'(lim);
  endfunction

endpackage
`default_nettype wire

// ----- src/companion_module_boot_sequencer.sv -----
// top level: input register, handshake, configuration and sequencer core
`default_nettype none
// Companion module boot sequencer. Each input beat is either a mode command or a
// 10 ms tick and yields exactly one result beat carrying the pin levels, mode and
// stage after that beat. A beat is held in the input register until the result
// register is free, and its result is then registered in the result register;
// one beat per cycle is sustained while results are taken, and the next-state logic
// between the two registers is the only path an item takes. Configuration writes
// take effect at once and should be issued only while no beat is in flight.
module companion_module_boot_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  cbs_pkg::cfg_idx_t  cfg_idx_i,
  input  cbs_pkg::cfg_word_t cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [7:0]         new_mode_i,
  input  logic               key_pressed_i,
  input  logic [1:0]         ui_state_i,
  input  logic               module_voice_i,
  input  logic               system_audio_busy_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               power_on_o,
  output logic               boot_pin_o,
  output logic               audio_to_module_o,
  output logic               bridge_on_o,
  output logic [1:0]         mode_now_o,
  output logic [2:0]         stage_now_o
);
  import cbs_pkg::*;

  item_t  item_q;
  logic   in_valid_q;
  logic   out_valid_q;
  logic   advance;
  cfg_t   cfg;
  state_t state;

  // the result register frees up in the same cycle it is taken
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.req_type <= req_type_i;
      item_q.new_mode <= new_mode_i;
      item_q.key      <= key_pressed_i;
      item_q.ui       <= ui_e'(ui_state_i);
      item_q.voice    <= module_voice_i;
      item_q.busy     <= system_audio_busy_i;
    end
  end

  cbs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  cbs_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (item_q),
    .cfg_i   (cfg),
    .state_o (state)
  );

  assign out_valid_o       = out_valid_q;
  assign power_on_o        = state.pwr;
  assign boot_pin_o        = state.boot;
  assign audio_to_module_o = state.audio;
  assign bridge_on_o       = state.bridge;
  assign mode_now_o        = state.mode;
  assign stage_now_o       = state.stage;

  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !advance)
    else $error("result overwritten while stalled");

  a_result_follows_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("beat processed without a result");

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q && $stable(item_q))
    else $error("pending beat lost from input register");

endmodule
`default_nettype wire

// ----- src/cbs_cfg.sv -----
// configuration register file of the boot sequencer
`default_nettype none
module cbs_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  cbs_pkg::cfg_idx_t cfg_idx_i,
  input  cbs_pkg::cfg_word_t cfg_data_i,
  output cbs_pkg::cfg_t     cfg_o
);
  import cbs_pkg::*;

  cfg_word_t regs_q [CFG_NUM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_NUM; i++) begin
        regs_q[i] <= CFG_RESET[i];
      end
    end else if (cfg_we_i && (int'(cfg_idx_i) < CFG_NUM)) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign cfg_o.power_off_wait    = regs_q[CFG_POWER_OFF_WAIT];
  assign cfg_o.power_to_cmd_wait = regs_q[CFG_POWER_TO_CMD_WAIT];
  assign cfg_o.cmd_hold_time     = regs_q[CFG_CMD_HOLD_TIME];
  assign cfg_o.boot_power_wait   = regs_q[CFG_BOOT_POWER_WAIT];
  assign cfg_o.long_press_time   = regs_q[CFG_LONG_PRESS_TIME];
  assign cfg_o.pulse_length      = regs_q[CFG_PULSE_LENGTH];

endmodule
`default_nettype wire

// ----- src/cbs_core.sv -----
// sequencer state, next-state logic for mode and tick beats, and pin levels
`default_nettype none
module cbs_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  cbs_pkg::item_t  item_i,
  input  cbs_pkg::cfg_t   cfg_i,
  output cbs_pkg::state_t state_o
);
  import cbs_pkg::*;

  state_t state_q, state_d;

  always_comb begin
    state_t s;
    mode_e  m;
    logic   due;
    logic   key;
    s   = state_q;
    m   = MODE_OFF;
    due = 1'b0;
    key = item_i.key;
    if (item_i.req_type) begin
      // mode beat
      m = (item_i.new_mode > 8'd3) ? MODE_OFF : mode_e'(item_i.new_mode[1:0]);
      if (s.mode == MODE_BOOT && m != MODE_BOOT) s.bridge = 1'b0;
      s.mode        = m;
      s.stage       = STG_IDLE;
      s.stage_timer = '0;
      unique case (m)
        MODE_OFF: s.pwr = 1'b0;
        MODE_ON:  s.pwr = 1'b1;
        MODE_PAIR: begin
          s.pwr   = 1'b0;
          s.stage = STG_WAIT_PWR;
        end
        MODE_BOOT: begin
          s.pwr   = 1'b0;
          s.boot  = 1'b1;
          s.stage = STG_BOOT_PWR;
        end
        default: s.pwr = 1'b0;
      endcase
    end else begin
      // tick beat
      s.stage_timer = sat_inc(s.stage_timer);
      if (s.press_seen) s.press_timer = sat_inc(s.press_timer);
      if (s.pulse_active) s.pulse_timer = sat_inc(s.pulse_timer);
      s.audio = (s.mode != MODE_OFF) && item_i.voice && !item_i.busy;

      if (s.mode == MODE_PAIR || s.mode == MODE_BOOT) begin
        unique case (s.stage)
          STG_WAIT_PWR: due = reached(s.stage_timer, cfg_i.power_off_wait);
          STG_CMD_ON:   due = reached(s.stage_timer, cfg_i.power_to_cmd_wait);
          STG_CMD_OFF:  due = reached(s.stage_timer, cfg_i.cmd_hold_time);
          STG_BOOT_PWR: due = reached(s.stage_timer, cfg_i.boot_power_wait);
          default:      due = 1'b0;
        endcase
        if (due) begin
          s.stage_timer = '0;
          unique case (s.stage)
            STG_WAIT_PWR: begin
              s.pwr   = 1'b1;
              s.stage = STG_CMD_ON;
            end
            STG_CMD_ON: begin
              s.boot  = 1'b1;
              s.stage = STG_CMD_OFF;
            end
            STG_CMD_OFF: begin
              s.boot  = 1'b0;
              s.stage = STG_MONITOR;
            end
            default: begin
              s.pwr    = 1'b1;
              s.bridge = 1'b1;
              s.stage  = STG_MONITOR;
            end
          endcase
        end
      end else begin
        // exit key rules
        unique case (item_i.ui)
          UI_LISTEN, UI_ANSWER: begin
            s.press_seen   = 1'b0;
            s.press_timer  = '0;
            s.long_ready   = 1'b0;
            s.pulse_active = 1'b0;
            s.pulse_timer  = '0;
            if (s.wait_release) begin
              if (!key) s.wait_release = 1'b0;
            end else begin
              s.boot = key;
            end
          end
          UI_REST: begin
            if (key) begin
              if (!s.press_seen) begin
                s.press_seen  = 1'b1;
                s.press_timer = '0;
              end else if (!s.long_ready &&
                           reached(s.press_timer, cfg_i.long_press_time)) begin
                s.long_ready   = 1'b1;
                s.wait_release = 1'b1;
              end
            end else begin
              s.press_seen   = 1'b0;
              s.press_timer  = '0;
              s.long_ready   = 1'b0;
              s.pulse_active = 1'b0;
              s.pulse_timer  = '0;
              s.boot         = 1'b0;
            end
            if (key && s.long_ready && !s.pulse_active) begin
              s.boot         = 1'b1;
              s.pulse_active = 1'b1;
              s.pulse_timer  = '0;
              s.long_ready   = 1'b0;
              s.press_seen   = 1'b1;
              s.press_timer  = '0;
            end
            // a zero pulse length ends the pulse on the tick that starts it
            if (s.pulse_active && reached(s.pulse_timer, cfg_i.pulse_length)) begin
              s.boot         = 1'b0;
              s.pulse_active = 1'b0;
            end
          end
          default: begin
            s.wait_release = 1'b0;
            s.press_seen   = 1'b0;
            s.press_timer  = '0;
            s.long_ready   = 1'b0;
            s.pulse_active = 1'b0;
            s.pulse_timer  = '0;
            s.boot         = 1'b0;
          end
        endcase
      end
    end
    state_d = s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

  a_stage_needs_seq_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.stage != STG_IDLE) |-> (state_q.mode == MODE_PAIR || state_q.mode == MODE_BOOT))
    else $error("sequence stage active outside pairing or boot");

  a_bridge_only_boot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bridge |-> (state_q.mode == MODE_BOOT))
    else $error("bridge on outside boot mode");

  a_pulse_has_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pulse_active |-> state_q.press_seen)
    else $error("pulse running without a held key");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> (state_q == $past(state_q)))
    else $error("state moved without a beat");

endmodule
`default_nettype wire
